// ----- rtl/prta_pkg.sv -----
// Shared types and constants of the pending response table.
package prta_pkg;
   localparam int DefaultDepth = 16;
   localparam int MaxResults = 16;
   localparam int KeyW = 32;
   localparam int PeerW = 48;
   localparam int TimeW = 20;
   localparam int ExtraW = 24;
   localparam int ReqW = 128;
   localparam int RspW = 112;

   typedef enum logic [1:0] {
      ACT_ENQ = 2'd0,
      ACT_DEQ = 2'd1,
      ACT_TICK = 2'd2,
      ACT_FLUSH = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_OK = 3'd0,
      ST_DUP = 3'd1,
      ST_FULL = 3'd2,
      ST_NOTFOUND = 3'd3,
      ST_TIMEOUT = 3'd4,
      ST_FLUSHED = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      EX_IDLE = 2'd0,
      EX_SCAN = 2'd1,
      EX_EMIT = 2'd2,
      EX_DONE = 2'd3
   } exec_state_type;

   typedef struct packed {
      action_type action;
      logic [KeyW-1:0] key;
      logic [PeerW-1:0] peer;
      logic [TimeW-1:0] timeout;
      logic [ExtraW-1:0] extra;
   } cmd_type;

   typedef struct packed {
      status_type status;
      logic [KeyW-1:0] key;
      logic [PeerW-1:0] peer;
      logic [15:0] cookie;
      logic [7:0] resend;
      logic [4:0] pending;
      logic last;
   } rsp_type;
endpackage

// ----- rtl/prta_front.sv -----
// Input stage: accepts request beats and queues decoded commands.
module prta_front (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   output logic req_tready,
   input logic [prta_pkg::ReqW-1:0] req_tdata,
   input logic [1:0] req_tuser,
   output logic cmd_valid,
   input logic cmd_ready,
   output prta_pkg::cmd_type cmd
);
   import prta_pkg::*;
   cmd_type q_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic wr_ff, wr_in, rd_ff, rd_in;
   logic push, pop;
   cmd_type c;

   always_comb begin
      c.action = action_type'(req_tuser);
      c.key = req_tdata[31:0];
      c.peer = req_tdata[79:32];
      c.timeout = req_tdata[99:80];
      c.extra = {req_tdata[107:100], req_tdata[123:108]};
   end

   assign req_tready = (cnt_ff != 2'd2);
   assign push = req_tvalid && req_tready;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign pop = cmd_valid && cmd_ready;
   assign cmd = q_ff[rd_ff];
   assign wr_in = push ? ~wr_ff : wr_ff;
   assign rd_in = pop ? ~rd_ff : rd_ff;
   assign cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         wr_ff <= 1'b0;
         rd_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         wr_ff <= wr_in;
         rd_ff <= rd_in;
      end
      if (push) q_ff[wr_ff] <= c;
   end
endmodule

// ----- rtl/prta_back.sv -----
// Execution stage: scans the slot table and produces response beats.
module prta_back #(
   parameter int TABLE_DEPTH = prta_pkg::DefaultDepth
) (
   input logic clock,
   input logic reset,
   input logic cmd_valid,
   output logic cmd_ready,
   input prta_pkg::cmd_type cmd,
   output logic rsp_tvalid,
   input logic rsp_tready,
   output prta_pkg::rsp_type rsp
);
   import prta_pkg::*;
   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic [KeyW-1:0] key_mem [TABLE_DEPTH];
   logic [PeerW-1:0] peer_mem [TABLE_DEPTH];
   logic [TimeW-1:0] rem_mem [TABLE_DEPTH];
   logic [ExtraW-1:0] extra_mem [TABLE_DEPTH];

   exec_state_type st_ff, st_in;
   cmd_type cur_ff, cur_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [4:0] pend_ff, pend_in;
   logic [4:0] nres_ff, nres_in;
   logic found_ff, found_in, free_ok_ff, free_ok_in;
   logic [IW-1:0] hit_ff, hit_in, free_ff, free_in;
   rsp_type out_ff, out_in;
   logic ov_ff, ov_in;
   logic [IW-1:0] i;
   logic rem_we;
   logic [TimeW-1:0] rem_wd;
   logic [IW-1:0] rem_wa;
   logic ins_we;
   logic last_slot;
   logic match, expire;

   assign i = idx_ff[IW-1:0];
   assign last_slot = (idx_ff == CW'(TABLE_DEPTH - 1));
   assign match = valid_ff[i] && key_mem[i] == cur_ff.key && peer_mem[i] == cur_ff.peer;
   assign expire = valid_ff[i] && rem_mem[i] <= TimeW'(1);
   assign cmd_ready = (st_ff == EX_IDLE) && !ov_ff;
   assign rsp_tvalid = ov_ff;
   assign rsp = out_ff;

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         EX_IDLE: if (cmd_valid && !ov_ff)
            st_in = (cmd.action == ACT_FLUSH) ? EX_IDLE : EX_SCAN;
         EX_SCAN: begin
            if (cur_ff.action == ACT_TICK) begin
               if (expire && nres_ff != 5'(MaxResults)) st_in = EX_EMIT;
               else if (last_slot) st_in = EX_DONE;
            end else if (last_slot || (match && cur_ff.action == ACT_DEQ)) st_in = EX_DONE;
         end
         EX_EMIT: if (!ov_ff) st_in = last_slot ? EX_DONE : EX_SCAN;
         EX_DONE: if (!ov_ff) st_in = EX_IDLE;
         default: st_in = EX_IDLE;
      endcase
   end

   always_comb begin
      cur_in = cur_ff;
      idx_in = idx_ff;
      pend_in = pend_ff;
      nres_in = nres_ff;
      found_in = found_ff;
      hit_in = hit_ff;
      free_ok_in = free_ok_ff;
      free_in = free_ff;
      valid_in = valid_ff;
      out_in = out_ff;
      ov_in = ov_ff && !rsp_tready;
      rem_we = 1'b0;
      rem_wa = i;
      rem_wd = rem_mem[i] - TimeW'(1);
      ins_we = 1'b0;
      unique case (st_ff)
         EX_IDLE: if (cmd_valid && !ov_ff) begin
            cur_in = cmd;
            idx_in = '0;
            nres_in = '0;
            found_in = 1'b0;
            free_ok_in = 1'b0;
            if (cmd.action == ACT_FLUSH) begin
               valid_in = '0;
               pend_in = '0;
               out_in = '0;
               out_in.status = ST_FLUSHED;
               out_in.last = 1'b1;
               ov_in = 1'b1;
            end
         end
         EX_SCAN: begin
            if (cur_ff.action == ACT_TICK) begin
               if (valid_ff[i]) begin
                  rem_we = 1'b1;
                  if (expire) rem_wd = '0;
               end
               if (expire && nres_ff != 5'(MaxResults)) begin
                  valid_in[i] = 1'b0;
                  pend_in = pend_ff - 5'd1;
                  nres_in = nres_ff + 5'd1;
               end else if (!last_slot) idx_in = idx_ff + CW'(1);
            end else begin
               if (match) begin
                  found_in = 1'b1;
                  hit_in = i;
               end
               if (!valid_ff[i] && !free_ok_ff) begin
                  free_ok_in = 1'b1;
                  free_in = i;
               end
               if (!last_slot && !(match && cur_ff.action == ACT_DEQ))
                  idx_in = idx_ff + CW'(1);
            end
         end
         EX_EMIT: if (!ov_ff) begin
            out_in.status = ST_TIMEOUT;
            out_in.key = key_mem[i];
            out_in.peer = peer_mem[i];
            out_in.cookie = extra_mem[i][15:0];
            out_in.resend = extra_mem[i][23:16];
            out_in.pending = pend_ff;
            out_in.last = 1'b1;
            for (int k = 0; k < TABLE_DEPTH; k++) begin
               if (k > int'(i) && valid_ff[k] && rem_mem[k] <= TimeW'(1)
                   && nres_ff != 5'(MaxResults)) out_in.last = 1'b0;
            end
            ov_in = 1'b1;
            if (!last_slot) idx_in = idx_ff + CW'(1);
         end
         EX_DONE: if (!ov_ff) begin
            out_in.key = cur_ff.key;
            out_in.peer = cur_ff.peer;
            out_in.cookie = '0;
            out_in.resend = '0;
            out_in.last = 1'b1;
            out_in.pending = pend_ff;
            ov_in = (cur_ff.action != ACT_TICK);
            if (cur_ff.action == ACT_ENQ) begin
               if (found_ff) out_in.status = ST_DUP;
               else if (!free_ok_ff) out_in.status = ST_FULL;
               else begin
                  out_in.status = ST_OK;
                  valid_in[free_ff] = 1'b1;
                  ins_we = 1'b1;
                  out_in.pending = pend_ff + 5'd1;
                  pend_in = pend_ff + 5'd1;
               end
            end else if (cur_ff.action == ACT_DEQ) begin
               if (found_ff) begin
                  out_in.status = ST_OK;
                  out_in.cookie = extra_mem[hit_ff][15:0];
                  valid_in[hit_ff] = 1'b0;
                  out_in.pending = pend_ff - 5'd1;
                  pend_in = pend_ff - 5'd1;
               end else out_in.status = ST_NOTFOUND;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= EX_IDLE;
         valid_ff <= '0;
         pend_ff <= '0;
         ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         valid_ff <= valid_in;
         pend_ff <= pend_in;
         ov_ff <= ov_in;
      end
      cur_ff <= cur_in;
      idx_ff <= idx_in;
      nres_ff <= nres_in;
      found_ff <= found_in;
      hit_ff <= hit_in;
      free_ok_ff <= free_ok_in;
      free_ff <= free_in;
      out_ff <= out_in;
      if (rem_we) rem_mem[rem_wa] <= rem_wd;
      if (ins_we) begin
         key_mem[free_ff] <= cur_ff.key;
         peer_mem[free_ff] <= cur_ff.peer;
         rem_mem[free_ff] <= cur_ff.timeout;
         extra_mem[free_ff] <= cur_ff.extra;
      end
   end
endmodule

// ----- rtl/pending_response_table_with_ageing.sv -----
// Pending response table with ageing: top level.
// Each request beat is queued, then executed by a slot scanner that visits one slot per
// cycle, pausing to emit each expired entry of a tick; enqueue and tick scan every slot,
// dequeue stops at the first match, and flush clears the table without a scan. A tick beat
// that expires nothing yields no response beat; expired entries come out in slot order.
module pending_response_table_with_ageing #(
   parameter int TABLE_DEPTH = prta_pkg::DefaultDepth
) (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   output logic req_tready,
   // msg_id, peer_addr, timeout_ms, resend_count, cookie_handle, pad
   input logic [prta_pkg::ReqW-1:0] req_tdata,
   // action
   input logic [1:0] req_tuser,
   output logic rsp_tvalid,
   input logic rsp_tready,
   // out_id, out_peer, out_cookie, out_resend, pending, pad
   output logic [prta_pkg::RspW-1:0] rsp_tdata,
   // status
   output logic [2:0] rsp_tuser,
   output logic rsp_tlast
);
   import prta_pkg::*;
   logic cmd_valid, cmd_ready;
   cmd_type cmd;
   rsp_type r;

   prta_front u_front (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .cmd_valid, .cmd_ready, .cmd
   );

   prta_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
      .clock, .reset, .cmd_valid, .cmd_ready, .cmd,
      .rsp_tvalid, .rsp_tready, .rsp(r)
   );

   assign rsp_tdata = {3'b000, r.pending, r.resend, r.cookie, r.peer, r.key};
   assign rsp_tuser = r.status;
   assign rsp_tlast = r.last;
endmodule
